/* hdl/hsl_pkg.sv */
// Shared constants and types for the HSL to RGB converter.
package hsl_pkg;

   // Number of color channels computed per item, and their slots.
   localparam int NUM_CHAN = 3;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

   // Clock cycles from an accepted item to its result strobe.
   localparam int LATENCY = 5;

endpackage

/* hdl/hsl_sector.sv */
// First pipeline stage: hue sector decode, ramp terms and chroma width term.
module hsl_sector #(
   parameter int HUE_BITS     = 12,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [HUE_BITS-1:0]             in_hue,
   input  logic [CHANNEL_BITS-1:0]         in_sat,
   input  logic [CHANNEL_BITS-1:0]         in_light,
   input  logic [CHANNEL_BITS-1:0]         in_alpha,
   output logic                            out_valid,
   output logic [CHANNEL_BITS-1:0]         out_sat,
   output logic [CHANNEL_BITS-2:0]         out_mid,
   output logic [CHANNEL_BITS-1:0]         out_light,
   output logic [CHANNEL_BITS-1:0]         out_alpha,
   output logic signed [HUE_BITS+1:0]      out_ramp [hsl_pkg::NUM_CHAN]
);
   import hsl_pkg::*;

   localparam int HW = HUE_BITS + 4;
   localparam int UW = HUE_BITS + 2;
   localparam logic signed [UW-1:0] U_POS = {2'b01, {HUE_BITS{1'b0}}};
   localparam logic signed [UW-1:0] U_NEG = {2'b11, {HUE_BITS{1'b0}}};

   typedef enum logic [2:0] {
      SEC_0 = 3'd0,
      SEC_1 = 3'd1,
      SEC_2 = 3'd2,
      SEC_3 = 3'd3,
      SEC_4 = 3'd4,
      SEC_5 = 3'd5
   } sector_type;

   logic [HW-1:0]          hh;
   sector_type             sector;
   logic [3:0]             odd;
   logic signed [HW:0]     center;
   logic signed [HW:0]     diff;
   logic signed [UW-1:0]   ramp;
   logic [CHANNEL_BITS-1:0] inv_light;

   logic                   valid_ff;
   logic [CHANNEL_BITS-1:0] sat_ff;
   logic [CHANNEL_BITS-2:0] mid_ff, mid_in;
   logic [CHANNEL_BITS-1:0] light_ff;
   logic [CHANNEL_BITS-1:0] alpha_ff;
   logic signed [UW-1:0]   ramp_ff [NUM_CHAN];
   logic signed [UW-1:0]   ramp_in [NUM_CHAN];

   // Twelve times the hue, in units of one turn scaled by 2^HUE_BITS.
   assign hh = (HW'(in_hue) << 3) + (HW'(in_hue) << 2);

   always_comb begin
      if (hh < (HW'(2) << HUE_BITS)) begin
         sector = SEC_0;
      end else if (hh < (HW'(4) << HUE_BITS)) begin
         sector = SEC_1;
      end else if (hh < (HW'(6) << HUE_BITS)) begin
         sector = SEC_2;
      end else if (hh < (HW'(8) << HUE_BITS)) begin
         sector = SEC_3;
      end else if (hh < (HW'(10) << HUE_BITS)) begin
         sector = SEC_4;
      end else begin
         sector = SEC_5;
      end
   end

   // The ramp crosses zero at the middle of its sector: an odd multiple of one unit.
   assign odd    = {sector, 1'b1};
   assign center = $signed({1'b0, odd, {HUE_BITS{1'b0}}});
   assign diff   = sector[0] ? (center - $signed({1'b0, hh}))
                             : ($signed({1'b0, hh}) - center);
   assign ramp   = diff[UW-1:0];

   always_comb begin
      case (sector)
         SEC_0: begin
            ramp_in[CH_RED] = U_POS; ramp_in[CH_GREEN] = ramp; ramp_in[CH_BLUE] = U_NEG;
         end
         SEC_1: begin
            ramp_in[CH_RED] = ramp; ramp_in[CH_GREEN] = U_POS; ramp_in[CH_BLUE] = U_NEG;
         end
         SEC_2: begin
            ramp_in[CH_RED] = U_NEG; ramp_in[CH_GREEN] = U_POS; ramp_in[CH_BLUE] = ramp;
         end
         SEC_3: begin
            ramp_in[CH_RED] = U_NEG; ramp_in[CH_GREEN] = ramp; ramp_in[CH_BLUE] = U_POS;
         end
         SEC_4: begin
            ramp_in[CH_RED] = ramp; ramp_in[CH_GREEN] = U_NEG; ramp_in[CH_BLUE] = U_POS;
         end
         default: begin
            ramp_in[CH_RED] = U_POS; ramp_in[CH_GREEN] = U_NEG; ramp_in[CH_BLUE] = ramp;
         end
      endcase
   end

   // Distance of lightness to the nearer end of the range; never above half scale.
   assign inv_light = ~in_light;
   assign mid_in    = (in_light < inv_light) ? in_light[CHANNEL_BITS-2:0]
                                             : inv_light[CHANNEL_BITS-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff   <= in_sat;
      mid_ff   <= mid_in;
      light_ff <= in_light;
      alpha_ff <= in_alpha;
      ramp_ff  <= ramp_in;
   end

   assign out_valid = valid_ff;
   assign out_sat   = sat_ff;
   assign out_mid   = mid_ff;
   assign out_light = light_ff;
   assign out_alpha = alpha_ff;
   assign out_ramp  = ramp_ff;

endmodule

/* hdl/hsl_mult.sv */
// Second and third pipeline stages: chroma width product, then its product with each ramp.
module hsl_mult #(
   parameter int HUE_BITS     = 12,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [CHANNEL_BITS-1:0]                  in_sat,
   input  logic [CHANNEL_BITS-2:0]                  in_mid,
   input  logic [CHANNEL_BITS-1:0]                  in_light,
   input  logic [CHANNEL_BITS-1:0]                  in_alpha,
   input  logic signed [HUE_BITS+1:0]               in_ramp [hsl_pkg::NUM_CHAN],
   output logic                                     out_valid,
   output logic [CHANNEL_BITS-1:0]                  out_light,
   output logic [CHANNEL_BITS-1:0]                  out_alpha,
   output logic signed [2*CHANNEL_BITS+HUE_BITS+1:0] out_prod [hsl_pkg::NUM_CHAN]
);
   import hsl_pkg::*;

   localparam int UW = HUE_BITS + 2;
   localparam int SW = 2 * CHANNEL_BITS - 1;
   localparam int PW = 2 * CHANNEL_BITS + HUE_BITS + 2;

   logic                    valid2_ff, valid3_ff;
   logic [SW-1:0]           sm_ff, sm_in;
   logic [CHANNEL_BITS-1:0] light2_ff, light3_ff;
   logic [CHANNEL_BITS-1:0] alpha2_ff, alpha3_ff;
   logic signed [UW-1:0]    ramp2_ff [NUM_CHAN];
   logic signed [PW-1:0]    prod_ff [NUM_CHAN];
   logic signed [PW-1:0]    prod_in [NUM_CHAN];

   assign sm_in = SW'(in_sat) * SW'(in_mid);

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod_in[c] = PW'($signed({1'b0, sm_ff})) * PW'(ramp2_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid2_ff <= in_valid;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sm_ff     <= sm_in;
      light2_ff <= in_light;
      alpha2_ff <= in_alpha;
      ramp2_ff  <= in_ramp;
      prod_ff   <= prod_in;
      light3_ff <= light2_ff;
      alpha3_ff <= alpha2_ff;
   end

   assign out_valid = valid3_ff;
   assign out_light = light3_ff;
   assign out_alpha = alpha3_ff;
   assign out_prod  = prod_ff;

endmodule

/* hdl/hsl_norm.sv */
// Fourth and fifth pipeline stages: offset, rounding, division by full scale and clamping.
module hsl_norm #(
   parameter int HUE_BITS     = 12,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [CHANNEL_BITS-1:0]                  in_light,
   input  logic [CHANNEL_BITS-1:0]                  in_alpha,
   input  logic signed [2*CHANNEL_BITS+HUE_BITS+1:0] in_prod [hsl_pkg::NUM_CHAN],
   output logic                                     out_valid,
   output logic [CHANNEL_BITS-1:0]                  out_chan [hsl_pkg::NUM_CHAN],
   output logic [CHANNEL_BITS-1:0]                  out_alpha
);
   import hsl_pkg::*;

   localparam int C  = CHANNEL_BITS;
   localparam int NW = 2 * C + HUE_BITS + 2;
   localparam int YW = 2 * C + 1;
   localparam int QW = C + 2;
   // Half of full scale times one hue unit, the rounding offset.
   localparam logic signed [NW-1:0] HALF =
      {{(NW - C - HUE_BITS + 1){1'b0}}, {C{1'b1}}, {(HUE_BITS - 1){1'b0}}};
   localparam logic [QW-1:0] CH_MAX = {2'b00, {C{1'b1}}};

   logic [2*C-1:0]       light_full;
   logic signed [NW-1:0] base;
   logic signed [NW-1:0] num [NUM_CHAN];
   logic signed [NW-1:0] rnd [NUM_CHAN];

   logic                 valid4_ff, valid5_ff;
   logic                 low_ff [NUM_CHAN];
   logic                 low_in [NUM_CHAN];
   logic [YW-1:0]        y_ff [NUM_CHAN];
   logic [YW-1:0]        y_in [NUM_CHAN];
   logic [C-1:0]         alpha4_ff, alpha5_ff;
   logic [YW:0]          sum [NUM_CHAN];
   logic [QW-1:0]        quo [NUM_CHAN];
   logic [C-1:0]         chan_ff [NUM_CHAN];
   logic [C-1:0]         chan_in [NUM_CHAN];

   // Lightness times full scale, then scaled by one hue unit.
   assign light_full = {in_light, {C{1'b0}}} - (2*C)'(in_light);
   assign base       = $signed({2'b00, light_full, {HUE_BITS{1'b0}}});

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         num[c]    = base + in_prod[c];
         rnd[c]    = num[c] + HALF;
         low_in[c] = num[c][NW-1] || (num[c] == '0);
         y_in[c]   = rnd[c][HUE_BITS +: YW];
      end
   end

   // Exact floor division by 2^C-1 for any value below 2^(2C)-1.
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum[c] = {1'b0, y_ff[c]} + (YW+1)'(y_ff[c] >> C) + (YW+1)'(1);
         quo[c] = sum[c][YW:C];
         if (low_ff[c]) begin
            chan_in[c] = '0;
         end else if (quo[c] > CH_MAX) begin
            chan_in[c] = {C{1'b1}};
         end else begin
            chan_in[c] = quo[c][C-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid4_ff <= in_valid;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      low_ff    <= low_in;
      y_ff      <= y_in;
      alpha4_ff <= in_alpha;
      chan_ff   <= chan_in;
      alpha5_ff <= alpha4_ff;
   end

   assign out_valid = valid5_ff;
   assign out_chan  = chan_ff;
   assign out_alpha = alpha5_ff;

endmodule

/* hdl/hsl_to_rgb.sv */
// Top level of the HSL to RGB pixel converter.
//
// Converts one pixel per clock from hue, saturation and lightness to red,
// green and blue, passing alpha through. An item is taken at every clock edge
// where start is high; busy is always low because the five-stage pipeline
// never has to hold anything back, and the receiver cannot stall it. Each
// result appears on the rsp_ ports for one cycle with rsp_strobe high, and
// results leave in the order the items came in. The depth is set by the two
// multipliers in series (saturation times the chroma term, then that times
// the hue ramp) and by the exact divide by full scale, each given a stage of
// its own. Hue is a fraction of a turn over 2^HUE_BITS; the other fields are
// fractions over 2^CHANNEL_BITS-1, and every channel is rounded to nearest
// with ties going up.
module hsl_to_rgb #(
   parameter int HUE_BITS     = 12,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [HUE_BITS-1:0]     req_hue,
   input  logic [CHANNEL_BITS-1:0] req_saturation,
   input  logic [CHANNEL_BITS-1:0] req_lightness,
   input  logic [CHANNEL_BITS-1:0] req_alpha_in,
   output logic                    rsp_strobe,
   output logic [CHANNEL_BITS-1:0] rsp_red,
   output logic [CHANNEL_BITS-1:0] rsp_green,
   output logic [CHANNEL_BITS-1:0] rsp_blue,
   output logic [CHANNEL_BITS-1:0] rsp_alpha_out
);
   import hsl_pkg::*;

   localparam int UW = HUE_BITS + 2;
   localparam int PW = 2 * CHANNEL_BITS + HUE_BITS + 2;

   logic                    accept;

   // Stage 1 outputs.
   logic                    s1_valid;
   logic [CHANNEL_BITS-1:0] s1_sat;
   logic [CHANNEL_BITS-2:0] s1_mid;
   logic [CHANNEL_BITS-1:0] s1_light;
   logic [CHANNEL_BITS-1:0] s1_alpha;
   logic signed [UW-1:0]    s1_ramp [NUM_CHAN];

   // Stage 3 outputs.
   logic                    s3_valid;
   logic [CHANNEL_BITS-1:0] s3_light;
   logic [CHANNEL_BITS-1:0] s3_alpha;
   logic signed [PW-1:0]    s3_prod [NUM_CHAN];

   // Stage 5 outputs.
   logic [CHANNEL_BITS-1:0] s5_chan [NUM_CHAN];

   // Every stage advances on every clock, so the pipeline is never busy.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   hsl_sector #(
      .HUE_BITS     (HUE_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_light  (req_lightness),
      .in_alpha  (req_alpha_in),
      .out_valid (s1_valid),
      .out_sat   (s1_sat),
      .out_mid   (s1_mid),
      .out_light (s1_light),
      .out_alpha (s1_alpha),
      .out_ramp  (s1_ramp)
   );

   hsl_mult #(
      .HUE_BITS     (HUE_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_sat    (s1_sat),
      .in_mid    (s1_mid),
      .in_light  (s1_light),
      .in_alpha  (s1_alpha),
      .in_ramp   (s1_ramp),
      .out_valid (s3_valid),
      .out_light (s3_light),
      .out_alpha (s3_alpha),
      .out_prod  (s3_prod)
   );

   hsl_norm #(
      .HUE_BITS     (HUE_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_light  (s3_light),
      .in_alpha  (s3_alpha),
      .in_prod   (s3_prod),
      .out_valid (rsp_strobe),
      .out_chan  (s5_chan),
      .out_alpha (rsp_alpha_out)
   );

   assign rsp_red   = s5_chan[CH_RED];
   assign rsp_green = s5_chan[CH_GREEN];
   assign rsp_blue  = s5_chan[CH_BLUE];

   // Every accepted item produces its strobe a fixed latency later.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result strobe missing after accepted item");

   // A result carries the alpha of the item taken one latency earlier.
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_alpha_out == $past(req_alpha_in, LATENCY)))
      else $error("alpha does not match its item");

   // A pixel with no saturation comes out grey at its own lightness.
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_saturation == '0)) |-> ##LATENCY
         ((rsp_red == $past(req_lightness, LATENCY)) &&
          (rsp_green == $past(req_lightness, LATENCY)) &&
          (rsp_blue == $past(req_lightness, LATENCY))))
      else $error("grey pixel does not keep its lightness");

endmodule
